// File: sv/ddp_pkg.sv
// Package for the DDP RGB packetizer: sizes, protocol constants, register
// indexes and the command that the front end queues for the back end.
// No dependencies.
`default_nettype none

package ddp_pkg;

  // Packet sizing
  localparam int MAX_PAYLOAD_BYTES = 1440;
  localparam int PKT_POS_W         = $clog2(MAX_PAYLOAD_BYTES + 1);

  // Field widths
  localparam int FRAME_W  = 24;
  localparam int PIX3_W   = FRAME_W + 2;
  localparam int OFFSET_W = 32;
  localparam int LEN_W    = 16;
  localparam int SEQ_W    = 4;
  localparam int BYTE_W   = 8;

  // Header constants
  localparam logic [BYTE_W-1:0] DDP_VERSION  = 8'h40;
  localparam logic [BYTE_W-1:0] DDP_PUSH     = 8'h01;
  localparam logic [BYTE_W-1:0] DDP_TYPE_RGB = 8'h0b;
  localparam logic [SEQ_W-1:0]  SEQ_TOP      = 4'd15;
  localparam logic [SEQ_W-1:0]  SEQ_FIRST    = 4'd1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_ID     = 1'b1;
  localparam logic [BYTE_W-1:0]    DEST_ID_RESET   = 8'h01;

  // Command queue between front and back end
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One payload byte, with the header it opens when has_hdr is set
  typedef struct packed {
    logic [BYTE_W-1:0]   data;
    logic                pkt_end;
    logic                has_hdr;
    logic                last_pkt;
    logic [SEQ_W-1:0]    seq;
    logic [BYTE_W-1:0]   dest;
    logic [OFFSET_W-1:0] offset;
    logic [LEN_W-1:0]    length;
  } cmd_t;

endpackage

`default_nettype wire

// File: sv/ddp_rgb_packetizer.sv
// Top level of the DDP RGB packetizer: front end, command queue, back end.
// Depends on ddp_pkg, ddp_front, ddp_fifo and ddp_back.
`default_nettype none

// The block takes one frame payload byte per transaction on the slave side
// and sends DDP packets one byte per transaction on the master side. Each
// packet carries at most 1440 data bytes and is preceded by a 10-byte header
// (version with the push flag on the frame's last packet, sequence number
// 1..15, data type RGB, destination id, big-endian 32-bit byte offset and
// big-endian 16-bit length). m_tlast marks the final byte of a packet and
// m_tuser marks the data byte that closes the output run of one input byte.
// Bytes outside an open frame, or beyond its announced length, are dropped.
// A new frame_start abandons any open frame at once. Rate: data flows at one
// byte per cycle while m_tready is high and no header is being sent; the
// first byte of each packet occupies the back end for its 10 header bytes and
// its data byte. The 4-entry command queue takes up to four further input
// bytes during a header, then s_tready drops. Write the configuration
// registers (pixel_start at index 0, destination_id at index 1) only while
// no frame bytes are in flight.

module ddp_rgb_packetizer
  import ddp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAME_W-1:0]   cfg_data,
  // Payload input
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // [7:0] data_byte, [31:8] frame_bytes
  input  logic                 s_tuser,   // [0] frame_start
  // Packet output
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [BYTE_W-1:0]    m_tdata,   // [7:0] out_byte
  output logic                 m_tlast,   // packet_end
  output logic                 m_tuser    // [0] run_last
);

  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  // Track frames and classify each accepted byte
  ddp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full)
  );

  // Decouple classification from byte emission
  ddp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  // Expand commands into header and data bytes
  ddp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_cmd  (pop_cmd),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

// File: sv/ddp_front.sv
// Front end of the DDP packetizer: configuration registers, frame and packet
// tracking, and classification of each payload byte into a queued command.
// Depends on ddp_pkg.
`default_nettype none

module ddp_front
  import ddp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAME_W-1:0]   cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,
  input  logic                 s_tuser,
  output logic                 push,
  output cmd_t                 push_cmd,
  input  logic                 full
);

  logic [PIX3_W-1:0]    pix3;
  logic [BYTE_W-1:0]    dest_id;
  logic [SEQ_W-1:0]     sequence_number;
  logic [FRAME_W-1:0]   frame_length;
  logic [FRAME_W-1:0]   frame_position;
  logic [PKT_POS_W-1:0] packet_position;
  logic                 frame_active;

  logic [BYTE_W-1:0]    in_data;
  logic [FRAME_W-1:0]   in_total;
  logic                 accept;
  logic [FRAME_W-1:0]   len_eff;
  logic [FRAME_W-1:0]   pos_eff;
  logic [PKT_POS_W-1:0] ppos_eff;
  logic                 act_eff;
  logic                 take;
  logic                 hdr;
  logic [FRAME_W-1:0]   remain;
  logic                 last_pkt;
  logic [FRAME_W-1:0]   pos_new;
  logic [PKT_POS_W-1:0] ppos_new;
  logic                 frame_done;
  logic                 pkt_end;
  logic [SEQ_W-1:0]     seq_next;

  assign cfg_ready = 1'b1;
  assign s_tready  = !full;
  assign accept    = s_tvalid && s_tready;
  assign in_data   = s_tdata[BYTE_W-1:0];
  assign in_total  = s_tdata[BYTE_W +: FRAME_W];

  always_comb begin
    len_eff    = s_tuser ? in_total : frame_length;
    pos_eff    = s_tuser ? '0 : frame_position;
    ppos_eff   = s_tuser ? '0 : packet_position;
    act_eff    = s_tuser ? (in_total != '0) : frame_active;
    take       = act_eff && (pos_eff < len_eff);
    hdr        = (ppos_eff == '0);
    remain     = len_eff - pos_eff;
    last_pkt   = (remain <= FRAME_W'(MAX_PAYLOAD_BYTES));
    pos_new    = pos_eff + FRAME_W'(1);
    ppos_new   = ppos_eff + PKT_POS_W'(1);
    frame_done = (pos_new >= len_eff);
    pkt_end    = (ppos_new >= PKT_POS_W'(MAX_PAYLOAD_BYTES)) || frame_done;
    seq_next   = (sequence_number >= SEQ_TOP) ? SEQ_FIRST : sequence_number + SEQ_W'(1);
  end

  assign push = accept && take;

  always_comb begin
    push_cmd          = '0;
    push_cmd.data     = in_data;
    push_cmd.pkt_end  = pkt_end;
    push_cmd.has_hdr  = hdr;
    push_cmd.last_pkt = last_pkt;
    push_cmd.seq      = seq_next;
    push_cmd.dest     = dest_id;
    push_cmd.offset   = OFFSET_W'(pix3) + OFFSET_W'(pos_eff);
    push_cmd.length   = last_pkt ? LEN_W'(remain) : LEN_W'(MAX_PAYLOAD_BYTES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix3            <= '0;
      dest_id         <= DEST_ID_RESET;
      sequence_number <= '0;
      frame_length    <= '0;
      frame_position  <= '0;
      packet_position <= '0;
      frame_active    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PIXEL_START: pix3    <= {cfg_data, 1'b0} + PIX3_W'(cfg_data);
          CFG_DEST_ID:     dest_id <= cfg_data[BYTE_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        frame_length    <= len_eff;
        frame_position  <= take ? pos_new : pos_eff;
        packet_position <= take ? (pkt_end ? '0 : ppos_new) : ppos_eff;
        frame_active    <= take ? !frame_done : act_eff;
        if (take && hdr) begin
          sequence_number <= seq_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/ddp_fifo.sv
// Short command queue between the packetizer's front and back end.
// Depends on ddp_pkg.
`default_nettype none

module ddp_fifo
  import ddp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + FIFO_PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + FIFO_CNT_W'(1);
        2'b01:   count <= count - FIFO_CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/ddp_back.sv
// Back end of the DDP packetizer: expands each queued command into its
// header bytes and data byte, behind a registered output stage.
// Depends on ddp_pkg.
`default_nettype none

module ddp_back
  import ddp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              pop_cmd,
  input  logic              empty,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [BYTE_W-1:0] m_tdata,
  output logic              m_tlast,
  output logic              m_tuser
);

  typedef enum logic [3:0] {
    B_VER, B_SEQ, B_TYPE, B_DEST, B_OFF3, B_OFF2, B_OFF1, B_OFF0, B_LEN1, B_LEN0, B_DATA
  } byte_idx_t;

  cmd_t              cur;
  logic              cur_valid;
  byte_idx_t         idx;
  logic              adv;
  logic              fire;
  logic              final_byte;
  logic              load;
  logic [BYTE_W-1:0] byte_sel;

  assign adv        = !m_tvalid || m_tready;
  assign fire       = cur_valid && adv;
  assign final_byte = (idx == B_DATA);
  assign load       = !empty && (!cur_valid || (fire && final_byte));
  assign pop        = load;

  always_comb begin
    unique case (idx)
      B_VER:   byte_sel = DDP_VERSION | (cur.last_pkt ? DDP_PUSH : '0);
      B_SEQ:   byte_sel = BYTE_W'(cur.seq);
      B_TYPE:  byte_sel = DDP_TYPE_RGB;
      B_DEST:  byte_sel = cur.dest;
      B_OFF3:  byte_sel = cur.offset[31:24];
      B_OFF2:  byte_sel = cur.offset[23:16];
      B_OFF1:  byte_sel = cur.offset[15:8];
      B_OFF0:  byte_sel = cur.offset[7:0];
      B_LEN1:  byte_sel = cur.length[15:8];
      B_LEN0:  byte_sel = cur.length[7:0];
      B_DATA:  byte_sel = cur.data;
      default: byte_sel = cur.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= B_VER;
      m_tvalid  <= 1'b0;
      m_tdata   <= '0;
      m_tlast   <= 1'b0;
      m_tuser   <= 1'b0;
    end else begin
      if (adv) begin
        m_tvalid <= cur_valid;
      end
      if (fire) begin
        m_tdata <= byte_sel;
        m_tlast <= final_byte && cur.pkt_end;
        m_tuser <= final_byte;
      end
      if (load) begin
        cur_valid <= 1'b1;
        idx       <= pop_cmd.has_hdr ? B_VER : B_DATA;
      end else if (fire && final_byte) begin
        cur_valid <= 1'b0;
      end else if (fire) begin
        idx <= byte_idx_t'(idx + 4'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= pop_cmd;
    end
  end

endmodule

`default_nettype wire

// File: sv/ddp_checker.sv
// Port-level assertions for the DDP RGB packetizer, bound to its top level.
// Depends on ddp_pkg and ddp_rgb_packetizer.
`default_nettype none

module ddp_checker
  import ddp_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [BYTE_W-1:0]    m_tdata,
  input logic                 m_tlast,
  input logic                 m_tuser
);

  logic seen_input;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_input <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      seen_input <= 1'b1;
    end
  end

  // A packet ends only on a data byte, never inside a header
  a_last_on_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("packet end on a header byte");

  // Output is quiet right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // No output before any input transaction since reset
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> seen_input)
    else $error("output with no input since reset");

  // A stalled output transaction holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled output changed");

endmodule

bind ddp_rgb_packetizer ddp_checker u_ddp_checker (.*);

`default_nettype wire
